// ===== rtl/pbisr_pkg.sv =====
// Shared types, widths and codes for the PBI subproblem replacement block.
// No dependencies; every other file of the block but pbisr_ram imports this package.
package pbisr_pkg;

  // default store geometry
  localparam int DEF_MAX_SUBPROBLEMS = 128;
  localparam int DEF_MAX_OBJECTIVES  = 8;

  // item field widths
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 7;
  localparam int OIDX_W   = 3;
  localparam int OBJ_W    = 32;
  localparam int WGT_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OCNT_W     = 4;
  localparam int SCNT_W     = 8;
  localparam int RLIM_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECTIVE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBPROBLEM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LIMIT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_WEIGHT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PARENT    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IDEAL     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFFSPRING = 2'd3;

  // datapath widths
  localparam int DIFF_W   = 33;  // objective minus ideal
  localparam int DPROD_W  = 50;  // diff times weight
  localparam int DOT_W    = 55;  // up to 16 diff*weight terms
  localparam int DVD_W    = 55;  // divider dividend and quotient
  localparam int NL_W     = 18;  // weight norm
  localparam int NSQ_W    = 36;  // sum of squared weights
  localparam int D1_W     = 38;  // projection length
  localparam int PROD_W   = 54;  // d1 times weight
  localparam int R_W      = 57;  // residual element
  localparam int MAG_W    = 29;  // saturated residual in units of 256
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int D2S_W    = 40;
  localparam int FIT_W    = 48;

  localparam logic [R_W-1:0] RES_SAT = R_W'((64'd1 << 37) - 64'd1);

  typedef struct packed {
    logic                start;
    logic [SQ_IN_W-1:0]  radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [NL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/pbisr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on pbisr_pkg for the field widths.
interface pbisr_in_if;
  import pbisr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [SLOT_W-1:0]        slot;
  logic [OIDX_W-1:0]        objective_index;
  logic signed [OBJ_W-1:0]  value;

  modport source (output valid, mode, slot, objective_index, value, input ready);
  modport sink   (input valid, mode, slot, objective_index, value, output ready);
endinterface

interface pbisr_out_if;
  import pbisr_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] replaced_slot;
  logic              replaced;
  logic              last;

  modport source (output valid, replaced_slot, replaced, last, input ready);
  modport sink   (input valid, replaced_slot, replaced, last, output ready);
endinterface

// ===== rtl/pbisr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pbisr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pbisr_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on pbisr_pkg for the request and response structs.
module pbisr_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pbisr_pkg::sqrt_req_t req,
  output pbisr_pkg::sqrt_rsp_t rsp
);
  import pbisr_pkg::*;

  logic [SQ_IN_W-1:0] n_r, res_r, bit_r, trial;
  logic [4:0]         cnt_r;
  logic               busy_r, done_r;

  assign trial = res_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one digit step per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.radicand;
      res_r <= '0;
      bit_r <= SQ_IN_W'(64'd1 << 62);
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[SQ_OUT_W-1:0];
endmodule

// ===== rtl/pbisr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pbisr_pkg for the request and response structs.
module pbisr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pbisr_pkg::div_req_t req,
  output pbisr_pkg::div_rsp_t rsp
);
  import pbisr_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_r, q_r;
  logic [NL_W-1:0]  d_r, rem_r;
  logic [NL_W:0]    trial;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  assign trial = {rem_r, dvd_r[DVD_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      d_r   <= req.divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      if (trial >= {1'b0, d_r}) begin
        rem_r <= NL_W'(trial - {1'b0, d_r});
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[NL_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;
endmodule

// ===== rtl/pbi_subproblem_replacement.sv =====
// PBI subproblem replacement: top level with weight and parent RAMs, the scan
// sequencer and the shared square root and divider units.
// Depends on pbisr_pkg, pbisr_if, pbisr_ram, pbisr_sqrt and pbisr_div.
//
// Usage: input items arrive on in_ch. Modes 0 to 2 load one weight, parent
// objective or ideal element each. Mode 3 stores one offspring element; the
// element at index objective_count-1 lowers the ideal point and starts a scan
// of subproblems 0 to subproblem_count-1. Each scan sends one result item per
// replaced slot on out_ch, then one closing item with last set. in_ch is held
// off while a scan runs.
// Each subproblem runs the serial d1*w multiply and the bit-serial divider
// once per element for parent and offspring, plus three square roots.
// A replaced slot adds parent write-back and result issue.
// Configuration is written on cfg_we with cfg_index and cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
// Reset (rst_n low, synchronous) restores the registers to 3, 128 and 2 and
// empties the output register; the stores keep no reset value.
// When out_ch stalls, the result waits in the output register and the scan
// holds before emitting the next one.
module pbi_subproblem_replacement #(
  parameter int MAX_SUBPROBLEMS = pbisr_pkg::DEF_MAX_SUBPROBLEMS,
  parameter int MAX_OBJECTIVES  = pbisr_pkg::DEF_MAX_OBJECTIVES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pbisr_in_if.sink                         in_ch,
  pbisr_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [pbisr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbisr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pbisr_pkg::*;

  localparam int DEPTH = MAX_SUBPROBLEMS * MAX_OBJECTIVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_OBJECTIVES);
  localparam int KCW   = $clog2(MAX_OBJECTIVES + 1);
  localparam int IW    = $clog2(MAX_SUBPROBLEMS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_ACC   = 5'd3;
  localparam logic [4:0] S_NSQ   = 5'd4;
  localparam logic [4:0] S_NLW   = 5'd5;
  localparam logic [4:0] S_DOT   = 5'd6;
  localparam logic [4:0] S_D1S   = 5'd7;
  localparam logic [4:0] S_D1W   = 5'd8;
  localparam logic [4:0] S_MINIT = 5'd9;
  localparam logic [4:0] S_MUL   = 5'd10;
  localparam logic [4:0] S_PJS   = 5'd11;
  localparam logic [4:0] S_PJW   = 5'd12;
  localparam logic [4:0] S_SQ    = 5'd13;
  localparam logic [4:0] S_D2S   = 5'd14;
  localparam logic [4:0] S_D2W   = 5'd15;
  localparam logic [4:0] S_FIT   = 5'd16;
  localparam logic [4:0] S_WB    = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;
  localparam logic [4:0] S_CLOSE = 5'd19;

  // configuration
  logic [OCNT_W-1:0] ocnt_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [RLIM_W-1:0] rlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= OCNT_W'(3);
      scnt_r <= SCNT_W'(128);
      rlim_r <= RLIM_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECTIVE_COUNT:   ocnt_r <= cfg_wdata[OCNT_W-1:0];
        REG_SUBPROBLEM_COUNT:  scnt_r <= cfg_wdata[SCNT_W-1:0];
        REG_REPLACEMENT_LIMIT: rlim_r <= cfg_wdata[RLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the store geometry
  logic [KCW-1:0] m_eff;
  logic [IW-1:0]  n_eff;

  always_comb begin
    if (ocnt_r == '0) begin
      m_eff = KCW'(1);
    end else if (int'(ocnt_r) > MAX_OBJECTIVES) begin
      m_eff = KCW'(MAX_OBJECTIVES);
    end else begin
      m_eff = KCW'(ocnt_r);
    end
    if (int'(scnt_r) > MAX_SUBPROBLEMS) begin
      n_eff = IW'(MAX_SUBPROBLEMS);
    end else begin
      n_eff = IW'(scnt_r);
    end
  end

  // sequencer registers
  logic [4:0]               state_r;
  logic [IW-1:0]            i_r;
  logic [RLIM_W-1:0]        repl_r;
  logic [KCW-1:0]           k_r;
  logic                     pass_r;
  logic [3:0]               mcnt_r;
  logic [NSQ_W-1:0]         nsq_r;
  logic [NL_W-1:0]          nl_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [D1_W-1:0]          d1_r;
  logic [PROD_W-1:0]        prod_r, mc_r;
  logic [WGT_W-1:0]         wsh_r;
  logic [MAG_W-1:0]         a_r;
  logic [SQ_IN_W-1:0]       sum_r;
  logic [D2S_W-1:0]         d2s_r;
  logic [FIT_W-1:0]         fp_r;

  // element buffers of the current subproblem
  logic [WGT_W-1:0]         w_a  [MAX_OBJECTIVES];
  logic signed [DIFF_W-1:0] dp_a [MAX_OBJECTIVES];
  logic signed [DIFF_W-1:0] do_a [MAX_OBJECTIVES];
  logic signed [OBJ_W-1:0]  ideal_r [MAX_OBJECTIVES];
  logic signed [OBJ_W-1:0]  off_r   [MAX_OBJECTIVES];

  // output register
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_repl_r, out_last_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  // input decode
  logic in_fire, idx_ok, slot_ok, trigger;
  logic [KW-1:0] in_k, kx;
  logic [AW-1:0] ld_addr, sc_addr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign idx_ok      = int'(in_ch.objective_index) < MAX_OBJECTIVES;
  assign slot_ok     = int'(in_ch.slot) < MAX_SUBPROBLEMS;
  assign in_k        = KW'(in_ch.objective_index);
  assign kx          = k_r[KW-1:0];
  assign trigger     = in_fire && (in_ch.mode == MODE_OFFSPRING) && idx_ok &&
                       (int'(in_ch.objective_index) == int'(m_eff) - 1);
  assign ld_addr     = AW'(int'(in_ch.slot) * MAX_OBJECTIVES + int'(in_ch.objective_index));
  assign sc_addr     = AW'(int'(i_r) * MAX_OBJECTIVES + int'(k_r));

  // weight and parent stores
  logic              w_we, p_we;
  logic [AW-1:0]     p_waddr;
  logic [OBJ_W-1:0]  p_wdata, p_rd;
  logic [WGT_W-1:0]  w_rd;

  assign w_we    = in_fire && (in_ch.mode == MODE_WEIGHT) && idx_ok && slot_ok;
  assign p_we    = (in_fire && (in_ch.mode == MODE_PARENT) && idx_ok && slot_ok) ||
                   (state_r == S_WB);
  assign p_waddr = (state_r == S_WB) ? sc_addr : ld_addr;
  assign p_wdata = (state_r == S_WB) ? off_r[kx] : in_ch.value;

  pbisr_ram #(.WIDTH(WGT_W), .DEPTH(DEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(ld_addr), .wdata(in_ch.value[WGT_W-1:0]),
    .raddr(sc_addr), .rdata(w_rd)
  );

  pbisr_ram #(.WIDTH(OBJ_W), .DEPTH(DEPTH)) u_pram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(sc_addr), .rdata(p_rd)
  );

  // shared arithmetic units
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  div_req_t  dv_req;
  div_rsp_t  dv_rsp;
  logic [DVD_W-1:0] dot_mag;

  assign dot_mag = dot_r[DOT_W-1] ? DVD_W'(-dot_r) : DVD_W'(dot_r);

  assign sq_req.start    = (state_r == S_NSQ) || (state_r == S_D2S);
  assign sq_req.radicand = (state_r == S_NSQ) ? SQ_IN_W'(nsq_r) : sum_r;
  assign dv_req.start    = (state_r == S_D1S) || (state_r == S_PJS);
  assign dv_req.dividend = (state_r == S_D1S) ? dot_mag : DVD_W'(prod_r);
  assign dv_req.divisor  = nl_r;

  pbisr_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));
  pbisr_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dv_req), .rsp(dv_rsp));

  // element arithmetic
  logic [2*WGT_W-1:0]       wsq;
  logic signed [DIFF_W-1:0] diffsel;
  logic signed [DPROD_W-1:0] dprod;
  logic signed [R_W-1:0]    rr;
  logic [R_W-1:0]           ra, rsat;
  logic [2*MAG_W-1:0]       asq;
  logic [FIT_W-1:0]         fit_c;
  logic                     k_last;

  assign wsq     = w_rd * w_rd;
  assign diffsel = pass_r ? do_a[kx] : dp_a[kx];
  assign dprod   = diffsel * $signed({1'b0, w_a[kx]});
  assign rr      = R_W'(diffsel) - $signed({2'b00, dv_rsp.quotient});
  assign ra      = rr[R_W-1] ? R_W'(-rr) : R_W'(rr);
  assign rsat    = (ra > RES_SAT) ? RES_SAT : ra;
  assign asq     = a_r * a_r;
  assign fit_c   = FIT_W'(d1_r) + (FIT_W'(d2s_r) << 4) + (FIT_W'(d2s_r) << 3) +
                   FIT_W'(d2s_r);
  assign k_last  = (k_r == m_eff - KCW'(1));

  // offspring buffer and ideal point
  always_ff @(posedge clk) begin
    if (in_fire && idx_ok) begin
      if (in_ch.mode == MODE_OFFSPRING) begin
        off_r[in_k] <= in_ch.value;
      end
      if (in_ch.mode == MODE_IDEAL) begin
        ideal_r[in_k] <= in_ch.value;
      end
    end
    // lower the ideal point on the triggering element
    if (trigger) begin
      for (int k = 0; k < MAX_OBJECTIVES; k++) begin
        logic signed [OBJ_W-1:0] ov;
        ov = (k == int'(in_k)) ? in_ch.value : off_r[k];
        if (k < int'(m_eff) && ov < ideal_r[k]) begin
          ideal_r[k] <= ov;
        end
      end
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      repl_r      <= '0;
      k_r         <= '0;
      pass_r      <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result or drop the accepted one
      if (((state_r == S_EMIT) || (state_r == S_CLOSE)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (trigger) begin
            i_r     <= '0;
            repl_r  <= '0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (i_r == n_eff || repl_r >= rlim_r) begin
            state_r <= S_CLOSE;
          end else begin
            k_r     <= '0;
            nsq_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_ACC;
        S_ACC: begin
          w_a[kx]  <= w_rd;
          dp_a[kx] <= DIFF_W'($signed(p_rd)) - DIFF_W'(ideal_r[kx]);
          do_a[kx] <= DIFF_W'(off_r[kx]) - DIFF_W'(ideal_r[kx]);
          nsq_r    <= nsq_r + NSQ_W'(wsq);
          if (k_last) begin
            state_r <= S_NSQ;
          end else begin
            k_r     <= k_r + KCW'(1);
            state_r <= S_RD;
          end
        end
        S_NSQ: state_r <= S_NLW;
        S_NLW: begin
          if (sq_rsp.done) begin
            nl_r <= sq_rsp.root[NL_W-1:0];
            if (sq_rsp.root[NL_W-1:0] == '0) begin
              i_r     <= i_r + IW'(1);
              state_r <= S_CHK;
            end else begin
              pass_r  <= 1'b0;
              k_r     <= '0;
              dot_r   <= '0;
              state_r <= S_DOT;
            end
          end
        end
        S_DOT: begin
          dot_r <= dot_r + DOT_W'(dprod);
          if (k_last) begin
            state_r <= S_D1S;
          end else begin
            k_r <= k_r + KCW'(1);
          end
        end
        S_D1S: state_r <= S_D1W;
        S_D1W: begin
          if (dv_rsp.done) begin
            d1_r    <= dv_rsp.quotient[D1_W-1:0];
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_MINIT;
          end
        end
        S_MINIT: begin
          mc_r    <= PROD_W'(d1_r);
          wsh_r   <= w_a[kx];
          prod_r  <= '0;
          mcnt_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // shift-add one weight bit
          if (wsh_r[0]) begin
            prod_r <= prod_r + mc_r;
          end
          mc_r   <= mc_r << 1;
          wsh_r  <= wsh_r >> 1;
          mcnt_r <= mcnt_r + 4'd1;
          if (mcnt_r == 4'd15) begin
            state_r <= S_PJS;
          end
        end
        S_PJS: state_r <= S_PJW;
        S_PJW: begin
          if (dv_rsp.done) begin
            a_r     <= rsat[MAG_W+7:8];
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sum_r <= sum_r + SQ_IN_W'(asq);
          if (k_last) begin
            state_r <= S_D2S;
          end else begin
            k_r     <= k_r + KCW'(1);
            state_r <= S_MINIT;
          end
        end
        S_D2S: state_r <= S_D2W;
        S_D2W: begin
          if (sq_rsp.done) begin
            d2s_r   <= {sq_rsp.root, 8'd0};
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          if (!pass_r) begin
            fp_r    <= fit_c;
            pass_r  <= 1'b1;
            k_r     <= '0;
            dot_r   <= '0;
            state_r <= S_DOT;
          end else if (fit_c < fp_r) begin
            k_r     <= '0;
            state_r <= S_WB;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_CHK;
          end
        end
        S_WB: begin
          if (k_last) begin
            state_r <= S_EMIT;
          end else begin
            k_r <= k_r + KCW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_slot_r  <= SLOT_W'(i_r);
            out_repl_r  <= 1'b1;
            out_last_r  <= 1'b0;
            repl_r      <= repl_r + RLIM_W'(1);
            i_r         <= i_r + IW'(1);
            state_r     <= S_CHK;
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            out_slot_r  <= '0;
            out_repl_r  <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.replaced_slot = out_slot_r;
  assign out_ch.replaced      = out_repl_r;
  assign out_ch.last          = out_last_r;
endmodule

// ===== rtl/pbisr_checker.sv =====
// Port-level checks of the result channel, bound to the top level.
// Depends on pbisr_pkg and on the top level pbi_subproblem_replacement.
module pbisr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pbisr_pkg::SLOT_W-1:0] out_slot,
  input logic                         out_replaced,
  input logic                         out_last
);
  import pbisr_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // exactly one of replaced and last on every result
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_replaced != out_last))
    else $error("result is neither a replacement nor a closing item");

  // closing result carries slot zero
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_slot == '0)
    else $error("closing result with nonzero slot");

  // output empty right after reset
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");
endmodule

bind pbi_subproblem_replacement pbisr_checker u_pbisr_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_slot(out_ch.replaced_slot), .out_replaced(out_ch.replaced),
  .out_last(out_ch.last)
);
